// File: rtl/knch_pkg.sv
// shared widths, word layout and action codes for the k-nearest candidate heap
package knch_pkg;

    // field widths of the stream words
    localparam int ACT_W      = 2;
    localparam int ID_FIELD_W = 20;
    localparam int DIST_W     = 32;
    localparam int COUNT_W    = 6;

    // packed word widths, data words padded to whole bytes
    localparam int S_TDATA_W  = 56;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 96;
    localparam int M_TUSER_W  = 2;

    // action codes carried in the input tuser
    typedef enum logic [ACT_W-1:0] {
        ACT_CLEAR = 2'd0,
        ACT_OFFER = 2'd1,
        ACT_DRAIN = 2'd2
    } action_t;

endpackage

// File: rtl/k_nearest_candidate_heap.sv
// k-nearest candidate heap: keeps the HEAP_SIZE nearest candidates of one search
//
// The block keeps the HEAP_SIZE nearest candidates of a search in one dual-read,
// single-write memory. An offer is stored when its squared distance is below the
// threshold (the search radius until the store is full, then the heap root). Entries
// are appended until the store is full, then the store is heapified in place into a
// max-heap; later accepted offers replace the root and sift down. One input word is
// processed at a time. Clear, a rejected offer, an appending offer and an unused action
// go from idle straight to loading the result word. An offer into the full heap sifts
// down level by level (at most floor(log2 HEAP_SIZE) + 1 levels); each level reads
// both children from memory and then compares them. The offer that fills the store adds
// the heapify pass, which sifts down each of the HEAP_SIZE/2 parents in turn. A drain
// reads each result word from memory, then loads it into the output register once that
// register is free; an empty store gives a single result word. The output register lets
// a new input word be taken while the last result still waits on m_tready.
module k_nearest_candidate_heap #(
    parameter int HEAP_SIZE = 32,
    parameter int ID_BITS   = 20
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input words
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // candidate_id [19:0], candidate_dist_sq [51:20], zero pad [55:52]
    input  logic [knch_pkg::S_TDATA_W-1:0]   s_tdata,
    // action [1:0]
    input  logic [knch_pkg::S_TUSER_W-1:0]   s_tuser,
    // result words
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // entry_id [19:0], entry_dist_sq [51:20], stored_count [57:52],
    // threshold_sq [89:58], zero pad [95:90]
    output logic [knch_pkg::M_TDATA_W-1:0]   m_tdata,
    // accepted [0], entry_valid [1]
    output logic [knch_pkg::M_TUSER_W-1:0]   m_tuser,
    output logic                             m_tlast,
    // search radius register write
    input  logic                             cfg_wvalid,
    output logic                             cfg_wready,
    input  logic [knch_pkg::DIST_W-1:0]      cfg_wdata
);
    import knch_pkg::*;

    localparam int ID_W    = (ID_BITS < ID_FIELD_W) ? ID_BITS : ID_FIELD_W;
    localparam int ENTRY_W = ID_W + DIST_W;
    localparam int POS_W   = $clog2(HEAP_SIZE);
    localparam int CNT_W   = $clog2(HEAP_SIZE + 1);
    localparam int CHILD_W = POS_W + 2;

    localparam logic [CNT_W-1:0]   FULL_CNT    = CNT_W'(HEAP_SIZE);
    localparam logic [CHILD_W-1:0] SIZE_C      = CHILD_W'(HEAP_SIZE);
    localparam logic [POS_W-1:0]   LAST_PARENT = POS_W'(HEAP_SIZE / 2 - 1);
    localparam logic [POS_W-1:0]   ROOT_POS    = '0;

    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,
        ST_HREAD   = 8'b0000_0010,
        ST_HLOAD   = 8'b0000_0100,
        ST_LOOKUP  = 8'b0000_1000,
        ST_COMPARE = 8'b0001_0000,
        ST_DRD     = 8'b0010_0000,
        ST_DOUT    = 8'b0100_0000,
        ST_FINISH  = 8'b1000_0000
    } state_t;

    // entry memory: {dist, id}
    logic [ENTRY_W-1:0] heap_mem [HEAP_SIZE];
    logic [ENTRY_W-1:0] rd_a_reg, rd_b_reg;

    state_t              state_reg, state_next;
    logic [DIST_W-1:0]   radius_reg, radius_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic                heap_ready_reg, heap_ready_next;
    logic [DIST_W-1:0]   root_dist_reg, root_dist_next;
    logic [ID_W-1:0]     node_id_reg, node_id_next;
    logic [DIST_W-1:0]   node_dist_reg, node_dist_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [POS_W-1:0]    hidx_reg, hidx_next;
    logic [POS_W-1:0]    didx_reg, didx_next;
    logic                heapify_reg, heapify_next;
    logic                has_l_reg, has_l_next;
    logic                has_r_reg, has_r_next;
    logic                acc_reg, acc_next;

    logic                m_tvalid_reg, m_tvalid_next;
    logic                out_acc_reg, out_acc_next;
    logic                out_valid_reg, out_valid_next;
    logic [ID_FIELD_W-1:0] out_id_reg, out_id_next;
    logic [DIST_W-1:0]   out_dist_reg, out_dist_next;
    logic [COUNT_W-1:0]  out_cnt_reg, out_cnt_next;
    logic [DIST_W-1:0]   out_thr_reg, out_thr_next;
    logic                out_last_reg, out_last_next;

    logic                mem_we;
    logic [POS_W-1:0]    mem_waddr;
    logic [ENTRY_W-1:0]  mem_wdata;
    logic                rd_en_a, rd_en_b;
    logic [POS_W-1:0]    rd_addr_a, rd_addr_b;

    logic                s_accept;
    logic                out_free;
    action_t             in_act;
    logic [ID_W-1:0]     in_id;
    logic [DIST_W-1:0]   in_dist;
    logic [DIST_W-1:0]   threshold;
    logic [CHILD_W-1:0]  c_l, c_r;
    logic [DIST_W-1:0]   dist_a, dist_b;
    logic                pick_right;
    logic [ENTRY_W-1:0]  child_entry;
    logic [CHILD_W-1:0]  child_idx;
    logic                sink;
    logic [CNT_W-1:0]    drain_next_cnt;

    // input word fields
    assign in_act   = action_t'(s_tuser[ACT_W-1:0]);
    assign in_id    = s_tdata[ID_W-1:0];
    assign in_dist  = s_tdata[ID_FIELD_W +: DIST_W];

    assign s_tready   = (state_reg == ST_IDLE);
    assign s_accept   = s_tvalid && s_tready;
    assign cfg_wready = 1'b1;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign threshold  = heap_ready_reg ? root_dist_reg : radius_reg;

    // children of the node being sifted
    assign c_l = {1'b0, pos_reg, 1'b1};
    assign c_r = c_l + CHILD_W'(1);

    // larger child, left on a tie
    assign dist_a      = rd_a_reg[ID_W +: DIST_W];
    assign dist_b      = rd_b_reg[ID_W +: DIST_W];
    assign pick_right  = has_r_reg && (dist_a < dist_b);
    assign child_entry = pick_right ? rd_b_reg : rd_a_reg;
    assign child_idx   = pick_right ? c_r : c_l;
    assign sink        = has_l_reg && (node_dist_reg < child_entry[ID_W +: DIST_W]);

    assign drain_next_cnt = CNT_W'(didx_reg) + CNT_W'(1);

    // sequencer
    always_comb begin
        state_next      = state_reg;
        radius_next     = radius_reg;
        fill_next       = fill_reg;
        heap_ready_next = heap_ready_reg;
        root_dist_next  = root_dist_reg;
        node_id_next    = node_id_reg;
        node_dist_next  = node_dist_reg;
        pos_next        = pos_reg;
        hidx_next       = hidx_reg;
        didx_next       = didx_reg;
        heapify_next    = heapify_reg;
        has_l_next      = has_l_reg;
        has_r_next      = has_r_reg;
        acc_next        = acc_reg;

        m_tvalid_next   = m_tvalid_reg && !m_tready;
        out_acc_next    = out_acc_reg;
        out_valid_next  = out_valid_reg;
        out_id_next     = out_id_reg;
        out_dist_next   = out_dist_reg;
        out_cnt_next    = out_cnt_reg;
        out_thr_next    = out_thr_reg;
        out_last_next   = out_last_reg;

        mem_we    = 1'b0;
        mem_waddr = pos_reg;
        mem_wdata = {node_dist_reg, node_id_reg};
        rd_en_a   = 1'b0;
        rd_en_b   = 1'b0;
        rd_addr_a = hidx_reg;
        rd_addr_b = hidx_reg;

        if (cfg_wvalid && cfg_wready) begin
            radius_next = cfg_wdata;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_FINISH;
                    acc_next   = 1'b0;
                    case (in_act)
                        ACT_CLEAR: begin
                            fill_next       = '0;
                            heap_ready_next = 1'b0;
                        end
                        ACT_OFFER: begin
                            if (in_dist < threshold) begin
                                acc_next = 1'b1;
                                if (heap_ready_reg) begin
                                    node_id_next   = in_id;
                                    node_dist_next = in_dist;
                                    pos_next       = ROOT_POS;
                                    heapify_next   = 1'b0;
                                    state_next     = ST_LOOKUP;
                                end else if (fill_reg < FULL_CNT) begin
                                    mem_we    = 1'b1;
                                    mem_waddr = fill_reg[POS_W-1:0];
                                    mem_wdata = {in_dist, in_id};
                                    fill_next = fill_reg + CNT_W'(1);
                                    if (fill_reg + CNT_W'(1) == FULL_CNT) begin
                                        hidx_next    = LAST_PARENT;
                                        heapify_next = 1'b1;
                                        state_next   = ST_HREAD;
                                    end
                                end
                            end
                        end
                        ACT_DRAIN: begin
                            if (fill_reg != '0) begin
                                didx_next  = '0;
                                state_next = ST_DRD;
                            end
                        end
                        default: begin
                            acc_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_HREAD: begin
                rd_en_a    = 1'b1;
                rd_addr_a  = hidx_reg;
                state_next = ST_HLOAD;
            end
            ST_HLOAD: begin
                node_id_next   = rd_a_reg[ID_W-1:0];
                node_dist_next = rd_a_reg[ID_W +: DIST_W];
                pos_next       = hidx_reg;
                state_next     = ST_LOOKUP;
            end
            ST_LOOKUP: begin
                has_l_next = (c_l < SIZE_C);
                has_r_next = (c_r < SIZE_C);
                rd_en_a    = (c_l < SIZE_C);
                rd_en_b    = (c_r < SIZE_C);
                rd_addr_a  = c_l[POS_W-1:0];
                rd_addr_b  = c_r[POS_W-1:0];
                state_next = ST_COMPARE;
            end
            ST_COMPARE: begin
                mem_we    = 1'b1;
                mem_waddr = pos_reg;
                if (sink) begin
                    // child moves up, node keeps sinking
                    mem_wdata  = child_entry;
                    pos_next   = child_idx[POS_W-1:0];
                    state_next = ST_LOOKUP;
                end else begin
                    mem_wdata = {node_dist_reg, node_id_reg};
                    if (!heapify_reg) begin
                        state_next = ST_FINISH;
                    end else if (hidx_reg == ROOT_POS) begin
                        heap_ready_next = 1'b1;
                        state_next      = ST_FINISH;
                    end else begin
                        hidx_next  = hidx_reg - POS_W'(1);
                        state_next = ST_HREAD;
                    end
                end
            end
            ST_DRD: begin
                rd_en_a    = 1'b1;
                rd_addr_a  = didx_reg;
                state_next = ST_DOUT;
            end
            ST_DOUT: begin
                if (out_free) begin
                    m_tvalid_next  = 1'b1;
                    out_acc_next   = 1'b0;
                    out_valid_next = 1'b1;
                    out_id_next    = ID_FIELD_W'(rd_a_reg[ID_W-1:0]);
                    out_dist_next  = rd_a_reg[ID_W +: DIST_W];
                    out_cnt_next   = COUNT_W'(fill_reg);
                    out_thr_next   = threshold;
                    out_last_next  = (drain_next_cnt == fill_reg);
                    if (drain_next_cnt == fill_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        didx_next  = didx_reg + POS_W'(1);
                        state_next = ST_DRD;
                    end
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_tvalid_next  = 1'b1;
                    out_acc_next   = acc_reg;
                    out_valid_next = 1'b0;
                    out_id_next    = '0;
                    out_dist_next  = '0;
                    out_cnt_next   = COUNT_W'(fill_reg);
                    out_thr_next   = threshold;
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // root distance shadow for the threshold
        if (mem_we && (mem_waddr == ROOT_POS)) begin
            root_dist_next = mem_wdata[ID_W +: DIST_W];
        end
    end

    // entry memory, two registered read ports
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            heap_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en_a) begin
            rd_a_reg <= heap_mem[rd_addr_a];
        end
        if (rd_en_b) begin
            rd_b_reg <= heap_mem[rd_addr_b];
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            radius_reg     <= '1;
            fill_reg       <= '0;
            heap_ready_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            radius_reg     <= radius_next;
            fill_reg       <= fill_next;
            heap_ready_reg <= heap_ready_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        root_dist_reg <= root_dist_next;
        node_id_reg   <= node_id_next;
        node_dist_reg <= node_dist_next;
        pos_reg       <= pos_next;
        hidx_reg      <= hidx_next;
        didx_reg      <= didx_next;
        heapify_reg   <= heapify_next;
        has_l_reg     <= has_l_next;
        has_r_reg     <= has_r_next;
        acc_reg       <= acc_next;
        out_acc_reg   <= out_acc_next;
        out_valid_reg <= out_valid_next;
        out_id_reg    <= out_id_next;
        out_dist_reg  <= out_dist_next;
        out_cnt_reg   <= out_cnt_next;
        out_thr_reg   <= out_thr_next;
        out_last_reg  <= out_last_next;
    end

    // result word
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'({out_thr_reg, out_cnt_reg, out_dist_reg, out_id_reg});
    assign m_tuser  = {out_valid_reg, out_acc_reg};
    assign m_tlast  = out_last_reg;

    // store never overfills
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FULL_CNT)
        else $error("fill count beyond heap size");

    // heap order only exists on a full store
    a_heap_full: assert property (@(posedge aclk) disable iff (!aresetn)
        heap_ready_reg |-> (fill_reg == FULL_CNT))
        else $error("heap marked ready on a partial store");

    // reads and writes never share a cycle
    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_we && (rd_en_a || rd_en_b)))
        else $error("memory read and write in the same cycle");

    // compare always uses data fetched by lookup
    a_compare_after_lookup: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COMPARE) |-> $past(state_reg == ST_LOOKUP))
        else $error("compare without child fetch");

    // an accepted word always starts work
    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (state_reg != ST_IDLE))
        else $error("accepted word produced no work");

endmodule

// File: test/tb.sv
// testbench for k_nearest_candidate_heap: random searches checked against a heap predictor
`timescale 1ns / 100ps

module tb;
    import knch_pkg::*;

    localparam int HEAP_N = 32;
    localparam int ID_W = 20;
    localparam int STALL_LIMIT = 4000;
    // the action code the block leaves unused
    localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;

    typedef struct packed {
        logic [ACT_W-1:0]   act;
        logic [ID_W-1:0]    id;
        logic [DIST_W-1:0]  dist_sq;
    } cmd_t;

    typedef struct packed {
        logic               accepted;
        logic               entry_valid;
        logic [ID_W-1:0]    entry_id;
        logic [DIST_W-1:0]  entry_dist;
        logic [COUNT_W-1:0] count;
        logic [DIST_W-1:0]  threshold;
        logic               last;
    } heap_word_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 m_tlast;
    logic                 cfg_wvalid = 1'b0;
    logic                 cfg_wready;
    logic [DIST_W-1:0]    cfg_wdata = '0;

    // stimulus and expectation stores
    cmd_t       cmd_queue[$];
    heap_word_t heap_words_due[$];
    cmd_t       cur_word = '0;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned stall_cycles = 0;

    // run statistics
    int unsigned mismatch_count = 0;
    int unsigned words_sent = 0;
    int unsigned words_checked = 0;
    int unsigned offers_stored = 0;
    int unsigned root_swaps = 0;
    int unsigned heaps_built = 0;
    int unsigned drains_seen = 0;
    int unsigned radius_writes = 0;

    // predictor state
    logic [ID_W-1:0]   heap_id[HEAP_N];
    logic [DIST_W-1:0] heap_dist[HEAP_N];
    int unsigned       held = 0;
    bit                heap_built = 1'b0;
    logic [DIST_W-1:0] radius_sq = '1;

    k_nearest_candidate_heap #(
        .HEAP_SIZE(HEAP_N),
        .ID_BITS(ID_W)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_wvalid(cfg_wvalid),
        .cfg_wready(cfg_wready),
        .cfg_wdata(cfg_wdata)
    );

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // acceptance threshold of the current search
    function automatic logic [DIST_W-1:0] acceptance_limit();
        return heap_built ? heap_dist[0] : radius_sq;
    endfunction

    // sink one node of the max-heap, left child wins ties
    function automatic void sink_node(int unsigned pos);
        logic [ID_W-1:0]   id_k;
        logic [DIST_W-1:0] d_k;
        int unsigned       c;
        id_k = heap_id[pos];
        d_k = heap_dist[pos];
        while (2 * pos + 1 < HEAP_N) begin
            c = 2 * pos + 1;
            if (c + 1 < HEAP_N && heap_dist[c] < heap_dist[c + 1])
                c++;
            if (d_k >= heap_dist[c])
                break;
            heap_id[pos] = heap_id[c];
            heap_dist[pos] = heap_dist[c];
            pos = c;
        end
        heap_id[pos] = id_k;
        heap_dist[pos] = d_k;
    endfunction

    function automatic void expect_word(logic acc, logic valid, logic [ID_W-1:0] id,
                                        logic [DIST_W-1:0] dist_sq, logic last);
        heap_word_t w;
        w.accepted = acc;
        w.entry_valid = valid;
        w.entry_id = id;
        w.entry_dist = dist_sq;
        w.count = held[COUNT_W-1:0];
        w.threshold = acceptance_limit();
        w.last = last;
        heap_words_due.push_back(w);
    endfunction

    // next state of the store and the result words of one input word
    function automatic void predict_heap_step(cmd_t c);
        logic acc;
        case (c.act)
            ACT_CLEAR: begin
                held = 0;
                heap_built = 1'b0;
                expect_word(1'b0, 1'b0, '0, '0, 1'b1);
            end
            ACT_OFFER: begin
                acc = 1'b0;
                if (c.dist_sq < acceptance_limit()) begin
                    acc = 1'b1;
                    offers_stored++;
                    if (heap_built) begin
                        heap_id[0] = c.id;
                        heap_dist[0] = c.dist_sq;
                        sink_node(0);
                        root_swaps++;
                    end else begin
                        heap_id[held] = c.id;
                        heap_dist[held] = c.dist_sq;
                        held++;
                        if (held == HEAP_N) begin
                            for (int p = HEAP_N / 2 - 1; p >= 0; p--)
                                sink_node(p);
                            heap_built = 1'b1;
                            heaps_built++;
                        end
                    end
                end
                expect_word(acc, 1'b0, '0, '0, 1'b1);
            end
            ACT_DRAIN: begin
                drains_seen++;
                if (held == 0)
                    expect_word(1'b0, 1'b0, '0, '0, 1'b1);
                for (int unsigned k = 0; k < held; k++)
                    expect_word(1'b0, 1'b1, heap_id[k], heap_dist[k], k + 1 == held);
            end
            default: begin
                expect_word(1'b0, 1'b0, '0, '0, 1'b1);
            end
        endcase
    endfunction

    // one line per mismatch, printing capped to keep the log short
    task automatic report(string what, logic [DIST_W-1:0] got, logic [DIST_W-1:0] want);
        if (mismatch_count < 40)
            $display("mismatch on %s, word %0d: got %h expected %h", what, words_checked,
                     got, want);
        mismatch_count++;
    endtask

    task automatic check_word();
        heap_word_t got;
        heap_word_t want;
        got.accepted = m_tuser[0];
        got.entry_valid = m_tuser[1];
        got.entry_id = m_tdata[19:0];
        got.entry_dist = m_tdata[51:20];
        got.count = m_tdata[57:52];
        got.threshold = m_tdata[89:58];
        got.last = m_tlast;
        if (heap_words_due.size() == 0) begin
            report("unexpected word", {m_tdata[89:58]}, '0);
        end else begin
            want = heap_words_due.pop_front();
            if (got.accepted !== want.accepted)
                report("accepted", DIST_W'(got.accepted), DIST_W'(want.accepted));
            if (got.entry_valid !== want.entry_valid)
                report("entry_valid", DIST_W'(got.entry_valid), DIST_W'(want.entry_valid));
            if (got.entry_id !== want.entry_id)
                report("entry_id", DIST_W'(got.entry_id), DIST_W'(want.entry_id));
            if (got.entry_dist !== want.entry_dist)
                report("entry_dist_sq", got.entry_dist, want.entry_dist);
            if (got.count !== want.count)
                report("stored_count", DIST_W'(got.count), DIST_W'(want.count));
            if (got.threshold !== want.threshold)
                report("threshold_sq", got.threshold, want.threshold);
            if (got.last !== want.last)
                report("last", DIST_W'(got.last), DIST_W'(want.last));
        end
        words_checked++;
    endtask

    // driver: presents queued words, predicts each one as it is taken
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                predict_heap_step(cur_word);
                words_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_word <= cmd_queue[0];
                    s_tdata <= {4'b0, cmd_queue[0].dist_sq, cmd_queue[0].id};
                    s_tuser <= cmd_queue[0].act;
                    s_tvalid <= 1'b1;
                    void'(cmd_queue.pop_front());
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: random back-pressure and result checks
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                check_word();
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog on cycles with no handshake anywhere
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_wvalid && cfg_wready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("no handshake for %0d cycles, %0d words still due", STALL_LIMIT,
                     heap_words_due.size());
            $display("Test completed with failures");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic void push_cmd(logic [ACT_W-1:0] act, logic [ID_W-1:0] id,
                                     logic [DIST_W-1:0] dist_sq);
        cmd_t c;
        c.act = act;
        c.id = id;
        c.dist_sq = dist_sq;
        cmd_queue.push_back(c);
    endfunction

    // candidate distance: extremes, repeated values for ties, full-range values, or spread up to span
    function automatic logic [DIST_W-1:0] pick_dist(logic [DIST_W-1:0] span);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 5)
            return '0;
        else if (r < 10)
            return '1;
        else if (r < 20)
            return $urandom;
        else if (r < 40)
            return $urandom_range(8, 1) * (span >> 3);
        return $urandom_range(span);
    endfunction

    // one search: mostly offers, some drains, spare codes and early clears
    task automatic push_search(int unsigned n, logic [DIST_W-1:0] span, bit lead_clear);
        int unsigned r;
        if (lead_clear)
            push_cmd(ACT_CLEAR, ID_W'($urandom_range(20'hFFFFF)), $urandom);
        for (int unsigned i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 2)
                push_cmd(ACT_CLEAR, ID_W'($urandom_range(20'hFFFFF)), $urandom);
            else if (r < 7)
                push_cmd(ACT_DRAIN, ID_W'($urandom_range(20'hFFFFF)), $urandom);
            else if (r < 10)
                push_cmd(ACT_SPARE, ID_W'($urandom_range(20'hFFFFF)), $urandom);
            else
                push_cmd(ACT_OFFER, ID_W'($urandom_range(20'hFFFFF)), pick_dist(span));
        end
        push_cmd(ACT_DRAIN, '0, '0);
    endtask

    // sender holds off until everything sent has come back
    task automatic wait_quiet();
        do
            @(negedge aclk);
        while (cmd_queue.size() != 0 || s_tvalid || heap_words_due.size() != 0);
    endtask

    task automatic write_radius(logic [DIST_W-1:0] value);
        @(posedge aclk);
        cfg_wvalid <= 1'b1;
        cfg_wdata <= value;
        do
            @(posedge aclk);
        while (!cfg_wready);
        cfg_wvalid <= 1'b0;
        radius_sq = value;
        radius_writes++;
        @(negedge aclk);
    endtask

    initial begin
        logic [DIST_W-1:0] rnd_radius;
        for (int k = 0; k < HEAP_N; k++) begin
            heap_id[k] = '0;
            heap_dist[k] = '0;
        end
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: reset radius, extremes of every field and action
        send_idle_pct = 23;
        recv_idle_pct = 83;
        push_cmd(ACT_CLEAR, '0, '0);
        push_cmd(ACT_DRAIN, '0, '0);
        push_cmd(ACT_SPARE, '1, '1);
        push_cmd(ACT_OFFER, '1, '0);
        push_cmd(ACT_OFFER, '0, '1);
        push_cmd(ACT_OFFER, 20'h55555, 32'hAAAA_AAAA);
        push_cmd(ACT_OFFER, 20'hAAAAA, 32'h5555_5555);
        push_cmd(ACT_OFFER, 20'h12345, 32'hFFFF_FFFE);
        push_cmd(ACT_DRAIN, '1, '1);
        push_cmd(ACT_CLEAR, '1, '1);
        push_cmd(ACT_DRAIN, '0, '0);
        push_cmd(ACT_OFFER, 20'h00007, 32'h0001_0000);
        wait_quiet();

        // zero radius rejects everything
        write_radius('0);
        push_cmd(ACT_OFFER, 20'h00100, '0);
        push_cmd(ACT_OFFER, ID_W'($urandom_range(20'hFFFFF)), $urandom);
        push_cmd(ACT_SPARE, '0, '0);
        push_cmd(ACT_DRAIN, '0, '0);
        push_cmd(ACT_CLEAR, '0, '0);
        push_cmd(ACT_OFFER, 20'h00200, '0);
        wait_quiet();

        // mid radius, candidates straddle it
        write_radius(32'h0010_0000);
        push_search(40, 32'h0018_0000, 1'b1);
        wait_quiet();

        // full radius, receiver mostly ready; pause halfway through the search
        send_idle_pct = 83;
        recv_idle_pct = 23;
        write_radius('1);
        push_search(35, '1, 1'b1);
        wait_quiet();
        push_search(15, '1, 1'b0);
        wait_quiet();

        // random radius, no idling on either side
        send_idle_pct = 0;
        recv_idle_pct = 0;
        rnd_radius = $urandom_range(32'hC000_0000, 32'h0100_0000);
        write_radius(rnd_radius);
        push_search(35, rnd_radius + (rnd_radius >> 2), 1'b1);
        wait_quiet();
        repeat (30) @(posedge aclk);

        $display("sent %0d input words, checked %0d result words, %0d drains",
                 words_sent, words_checked, drains_seen);
        $display("%0d offers stored, %0d heaps built, %0d root replacements, %0d radius writes",
                 offers_stored, heaps_built, root_swaps, radius_writes);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: filelist.f
rtl/knch_pkg.sv
rtl/k_nearest_candidate_heap.sv
test/tb.sv
